FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted identifier set.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/sis_pkg.sv
// Package of the sorted identifier set: sizes, codes, shared types and helpers.
// Depends on nothing; every other file but assert_macros.svh imports it.
package sis_pkg;

	localparam int CAPACITY   = 64;
	localparam int IDENT_BITS = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int MODE_BITS  = 2;
	localparam int IN_ID_BITS = 32;
	localparam int STAT_BITS  = 2;
	localparam int POS_BITS   = 6;
	localparam int COUNT_BITS = 7;

	localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_TEST   = 2'd2;

	typedef enum logic [STAT_BITS-1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} sis_status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} sis_state_t;

	typedef logic [IDENT_BITS-1:0] ident_t;

	typedef struct packed {
		logic   fire;
		logic   ins;
		logic   rem;
		ident_t id;
	} sis_cmd_t;

	typedef struct packed {
		logic lt;
		logic first;
		logic hit;
	} sis_flags_t;

	function automatic ident_t to_ident(input logic [IN_ID_BITS-1:0] x);
		logic [IN_ID_BITS+IDENT_BITS-1:0] w;
		w = {{IDENT_BITS{1'b0}}, x};
		return w[IDENT_BITS-1:0];
	endfunction

	function automatic logic [POS_BITS-1:0] fit_pos(input logic [IDX_W-1:0] p);
		logic [IDX_W+POS_BITS-1:0] w;
		w = {{POS_BITS{1'b0}}, p};
		return w[POS_BITS-1:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] fit_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_BITS-1:0] w;
		w = {{COUNT_BITS{1'b0}}, c};
		return w[COUNT_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/sis_if.sv
// Request and response channel interfaces of the sorted identifier set.
// Depends on sis_pkg for the field widths.
interface sis_req_if;
	import sis_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MODE_BITS-1:0]  mode;
	logic [IN_ID_BITS-1:0] ident;

	modport source (output valid, output mode, output ident, input ready);
	modport sink (input valid, input mode, input ident, output ready);
endinterface

interface sis_rsp_if;
	import sis_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STAT_BITS-1:0]  status;
	logic [POS_BITS-1:0]   position;
	logic [COUNT_BITS-1:0] entry_count;

	modport source (output valid, output status, output position, output entry_count,
		input ready);
	modport sink (input valid, input status, input position, input entry_count,
		output ready);
endinterface

FILE: hw/rtl/sis_cell.sv
// One cell of the sorted chain: holds a single identifier, compares it and shifts.
// Depends on sis_pkg for the command and flag types.
module sis_cell (
	input  logic                clk,
	input  sis_pkg::sis_cmd_t   cmd,
	input  logic                valid,
	input  logic                left_lt,
	input  sis_pkg::ident_t     left_entry,
	input  sis_pkg::ident_t     right_entry,
	output sis_pkg::sis_flags_t flags,
	output sis_pkg::ident_t     entry
);
	import sis_pkg::*;

	ident_t entry_q;
	logic   lt;
	logic   first;

	assign lt          = valid && (entry_q < cmd.id);
	assign first       = !lt && left_lt;
	assign flags.lt    = lt;
	assign flags.first = first;
	assign flags.hit   = first && valid && (entry_q == cmd.id);
	assign entry       = entry_q;

	// Cells at or above the sorted place move one step up on insert, down on remove.
	always_ff @(posedge clk) begin
		if (cmd.fire && !lt) begin
			if (cmd.ins) begin
				entry_q <= first ? cmd.id : left_entry;
			end else if (cmd.rem) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule

FILE: hw/rtl/sis_encode.sv
// Turns the boundary flags of the cell chain into a found bit and a sorted position.
// Depends on sis_pkg for the sizes.
module sis_encode (
	input  logic [sis_pkg::CAPACITY-1:0] first_vec,
	input  logic [sis_pkg::CAPACITY-1:0] hit_vec,
	input  logic                         last_lt,
	output logic                         found,
	output logic [sis_pkg::IDX_W-1:0]    pos
);
	import sis_pkg::*;

	logic [IDX_W-1:0] pos_or;

	always_comb begin
		pos_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_vec[i]) begin
				pos_or = pos_or | IDX_W'(i);
			end
		end
	end

	// When every cell lies below the identifier the place is past the end and saturates.
	assign pos   = last_lt ? IDX_W'(CAPACITY - 1) : pos_or;
	assign found = |hit_vec;

endmodule

FILE: hw/rtl/sorted_id_set_core.sv
// Top level of the sorted identifier set: control, the cell chain and the result register.
// Depends on sis_pkg, sis_if, sis_cell, sis_encode and assert_macros.svh.
//
// Channel  Direction  Transfer carries
// req      in         mode, ident
// rsp      out        status, position, entry_count
//
// Each request is captured in ST_IDLE; in ST_EXEC every cell compares in parallel and
// the chain shifts. No new request is taken until the last one has executed.
// The execute cycle waits while an earlier response is still held and not taken.
// Reset clears the entry count and the control state; cell contents start undefined.
`include "assert_macros.svh"

module sorted_id_set_core (
	input  logic     clk,
	input  logic     arst_n,
	sis_req_if.sink  req,
	sis_rsp_if.source rsp
);
	import sis_pkg::*;

	sis_state_t           state_q;
	sis_state_t           state_nxt;
	logic [MODE_BITS-1:0] mode_q;
	ident_t               id_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 rsp_valid_q;
	sis_status_t          status_q;
	sis_status_t          status_nxt;
	logic [IDX_W-1:0]     pos_q;
	logic [CNT_W-1:0]     cnt_out_q;

	logic                 exec_fire;
	logic                 found;
	logic                 full;
	logic                 op_ins;
	logic                 op_rem;
	logic [IDX_W-1:0]     pos;
	sis_cmd_t             cmd;
	sis_flags_t           flags [CAPACITY];
	ident_t               entries [CAPACITY];
	logic [CAPACITY-1:0]  first_vec;
	logic [CAPACITY-1:0]  hit_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		exec_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					exec_fire = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			id_q   <= to_ident(req.ident);
		end
	end

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign op_ins = (mode_q == MODE_INSERT) && !found && !full;
	assign op_rem = (mode_q == MODE_REMOVE) && found;

	assign cmd.fire = exec_fire;
	assign cmd.ins  = op_ins;
	assign cmd.rem  = op_rem;
	assign cmd.id   = id_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   cell_valid;
		logic   left_lt;
		ident_t left_entry;
		ident_t right_entry;

		assign cell_valid = (count_q > CNT_W'(i));
		if (i == 0) begin : g_head
			assign left_lt    = 1'b1;
			assign left_entry = id_q;
		end else begin : g_body
			assign left_lt    = flags[i-1].lt;
			assign left_entry = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entries[i];
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		sis_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.valid       (cell_valid),
			.left_lt     (left_lt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.flags       (flags[i]),
			.entry       (entries[i])
		);

		assign first_vec[i] = flags[i].first;
		assign hit_vec[i]   = flags[i].hit;
	end

	sis_encode u_encode (
		.first_vec (first_vec),
		.hit_vec   (hit_vec),
		.last_lt   (flags[CAPACITY-1].lt),
		.found     (found),
		.pos       (pos)
	);

	always_comb begin
		count_nxt = count_q;
		if (op_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (op_rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
		case (mode_q)
			MODE_INSERT: status_nxt = found ? STAT_MISS : (full ? STAT_FULL : STAT_DONE);
			MODE_REMOVE: status_nxt = found ? STAT_DONE : STAT_MISS;
			default:     status_nxt = found ? STAT_DONE : STAT_MISS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q  <= status_nxt;
			pos_q     <= pos;
			cnt_out_q <= count_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.position    = fit_pos(pos_q);
	assign rsp.entry_count = fit_count(cnt_out_q);

	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`ASSERT_IMPL(a_one_boundary, clk, arst_n, state_q == ST_EXEC, $onehot0(first_vec))
	`ASSERT_NEXT(a_ins_grows, clk, arst_n, exec_fire && op_ins, count_q == $past(count_q) + CNT_W'(1))
	`ASSERT_IMPL(a_full_status, clk, arst_n, rsp_valid_q && status_q == STAT_FULL, cnt_out_q == CNT_W'(CAPACITY))

endmodule

FILE: tb/tb_sorted_id_set_core.sv
// Testbench for sorted_id_set_core: directed and random insert, remove and lookup transfers,
// each response checked field by field against typed values or a predictor of the sorted table.
// Depends on sis_pkg, sis_if and the RTL of the block.
module tb_sorted_id_set_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sis_pkg::*;

	localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_TAIL   = 150;
	localparam int HOLD_AT      = 1500;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		sis_status_t          status;
		logic [POS_BITS-1:0]   position;
		logic [COUNT_BITS-1:0] entry_count;
	} set_reply_t;

	typedef struct {
		logic [MODE_BITS-1:0] op;
		ident_t               id;
		bit                   typed;
		set_reply_t           reply;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sis_req_if req_bus();
	sis_rsp_if rsp_bus();

	sorted_id_set_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ident_t     held_ids [CAPACITY];
	int         held_cnt;
	set_reply_t expected_replies [$];
	set_reply_t head_reply;
	int         errors;
	int         cycle_cnt;
	bit         quiet;
	step_row_t  opening_rows [17];

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Applies one operation to the table and returns the response it must produce.
	function automatic set_reply_t apply_op(input logic [MODE_BITS-1:0] m, input ident_t id);
		int slot;
		int k;
		bit hit;
		set_reply_t r;
		slot = 0;
		while (slot < held_cnt && held_ids[slot] < id)
			slot++;
		hit = (slot < held_cnt) && (held_ids[slot] == id);
		r.status = STAT_MISS;
		case (m)
			MODE_INSERT: begin
				if (hit) begin
					r.status = STAT_MISS;
				end else if (held_cnt >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					for (k = held_cnt; k > slot; k--)
						held_ids[k] = held_ids[k-1];
					held_ids[slot] = id;
					held_cnt++;
					r.status = STAT_DONE;
				end
			end
			MODE_REMOVE: begin
				if (hit) begin
					for (k = slot; k + 1 < held_cnt; k++)
						held_ids[k] = held_ids[k+1];
					held_cnt--;
					r.status = STAT_DONE;
				end
			end
			default: r.status = hit ? STAT_DONE : STAT_MISS;
		endcase
		r.position = (slot > CAPACITY - 1) ? POS_BITS'(CAPACITY - 1) : POS_BITS'(slot);
		r.entry_count = COUNT_BITS'(held_cnt);
		return r;
	endfunction

	function automatic logic [MODE_BITS-1:0] pick_mode(input bit filling);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return MODE_SPARE;
		if (roll < 8)
			return MODE_BITS'($urandom_range(0, 3));
		if (filling) begin
			if (roll < 72)
				return MODE_INSERT;
			if (roll < 84)
				return MODE_REMOVE;
			return MODE_TEST;
		end
		if (roll < 22)
			return MODE_INSERT;
		if (roll < 80)
			return MODE_REMOVE;
		return MODE_TEST;
	endfunction

	// Identifiers lean towards those already held and their neighbours, so that
	// hits, misses beside a hit and removals are all frequent.
	function automatic ident_t pick_ident(input bit filling);
		int unsigned roll;
		int unsigned near;
		ident_t base;
		roll = $urandom_range(0, 99);
		near = filling ? 35 : 65;
		if (held_cnt > 0 && roll < near) begin
			base = held_ids[$urandom_range(0, held_cnt - 1)];
			case ($urandom_range(0, 5))
				0: return base + 1;
				1: return base - 1;
				default: return base;
			endcase
		end
		if (roll < near + 10)
			return $urandom_range(0, 1) ? '0 : '1;
		if (roll < near + 20)
			return ident_t'($urandom_range(0, 255));
		return $urandom();
	endfunction

	task automatic offer(input logic [MODE_BITS-1:0] m, input ident_t id);
		req_bus.valid <= 1'b1;
		req_bus.mode <= m;
		req_bus.ident <= id;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
	endtask

	task automatic pause_sender(input bit calm);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		int n;
		int linger;
		bit filling;
		logic [MODE_BITS-1:0] m;
		ident_t id;
		set_reply_t r;

		errors = 0;
		held_cnt = 0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.mode <= MODE_INSERT;
		req_bus.ident <= '0;

		opening_rows = '{
			'{MODE_TEST,   32'h0000_0000, 1'b1, '{STAT_MISS, 6'd0, 7'd0}},
			'{MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, '{STAT_MISS, 6'd0, 7'd0}},
			'{MODE_SPARE,  32'h0000_0005, 1'b1, '{STAT_MISS, 6'd0, 7'd0}},
			'{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, '{STAT_DONE, 6'd0, 7'd1}},
			'{MODE_INSERT, 32'h0000_0000, 1'b1, '{STAT_DONE, 6'd0, 7'd2}},
			'{MODE_INSERT, 32'h0000_0000, 1'b1, '{STAT_MISS, 6'd0, 7'd2}},
			'{MODE_INSERT, 32'h8000_0000, 1'b1, '{STAT_DONE, 6'd1, 7'd3}},
			'{MODE_INSERT, 32'h7FFF_FFFF, 1'b1, '{STAT_DONE, 6'd1, 7'd4}},
			'{MODE_TEST,   32'hFFFF_FFFF, 1'b1, '{STAT_DONE, 6'd3, 7'd4}},
			'{MODE_TEST,   32'h8000_0001, 1'b1, '{STAT_MISS, 6'd3, 7'd4}},
			'{MODE_SPARE,  32'h7FFF_FFFF, 1'b1, '{STAT_DONE, 6'd1, 7'd4}},
			'{MODE_INSERT, 32'h5555_5555, 1'b0, '{STAT_DONE, 6'd0, 7'd0}},
			'{MODE_INSERT, 32'hAAAA_AAAA, 1'b0, '{STAT_DONE, 6'd0, 7'd0}},
			'{MODE_REMOVE, 32'h7FFF_FFFF, 1'b0, '{STAT_DONE, 6'd0, 7'd0}},
			'{MODE_REMOVE, 32'h0000_0000, 1'b1, '{STAT_DONE, 6'd0, 7'd4}},
			'{MODE_REMOVE, 32'h0000_0000, 1'b1, '{STAT_MISS, 6'd0, 7'd4}},
			'{MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, '{STAT_DONE, 6'd3, 7'd3}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i]) begin
			offer(opening_rows[i].op, opening_rows[i].id);
			r = apply_op(opening_rows[i].op, opening_rows[i].id);
			expected_replies.push_back(opening_rows[i].typed ? opening_rows[i].reply : r);
			pause_sender(1'b0);
		end

		filling = 1'b1;
		linger = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if (filling && held_cnt == CAPACITY && linger == 0)
				linger = $urandom_range(20, 40);
			if (linger > 0) begin
				linger--;
				if (linger == 0)
					filling = 1'b0;
			end
			if (!filling && held_cnt == 0)
				filling = 1'b1;
			m = pick_mode(filling);
			id = pick_ident(filling);
			offer(m, id);
			expected_replies.push_back(apply_op(m, id));
			pause_sender(quiet || ((n / 100) % 3 == 0));
		end
		req_bus.valid <= 1'b0;

		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : receiver
		int ticks;
		bit held_off;
		ticks = 0;
		held_off = 1'b0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			ticks++;
			if (!held_off && ticks >= HOLD_AT) begin
				held_off = 1'b1;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_bus.ready <= 1'b1;
			end else if (!quiet && (ticks / 150) % 3 != 0 && $urandom_range(0, 4) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				note_mismatch("unexpected transfer, status", 32'(rsp_bus.status), '0);
			end else begin
				head_reply = expected_replies.pop_front();
				if (rsp_bus.status !== head_reply.status)
					note_mismatch("status", 32'(rsp_bus.status), 32'(head_reply.status));
				if (rsp_bus.position !== head_reply.position)
					note_mismatch("position", 32'(rsp_bus.position),
						32'(head_reply.position));
				if (rsp_bus.entry_count !== head_reply.entry_count)
					note_mismatch("entry_count", 32'(rsp_bus.entry_count),
						32'(head_reply.entry_count));
			end
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
